>>> hdl/ustcd_pkg.sv
package ustcd_pkg;

    localparam int unsigned ALU_W = 32;

    localparam logic [11:0]      EPOCH_YEAR    = 12'd1970;
    localparam logic [ALU_W-1:0] DAYS_PER_YEAR = 32'd365;
    localparam logic [ALU_W-1:0] SEC_PER_MIN   = 32'd60;
    localparam logic [ALU_W-1:0] MIN_PER_HOUR  = 32'd60;
    localparam logic [ALU_W-1:0] HOUR_PER_DAY  = 32'd24;
    localparam logic [ALU_W-1:0] DAY_PER_WEEK  = 32'd7;
    localparam logic [ALU_W-1:0] WDAY_OFFSET   = 32'd4;
    localparam logic [3:0]       LAST_MONTH    = 4'd12;
    localparam logic [3:0]       MARCH         = 4'd3;

    // reciprocals, exact with the shifts used: 60 and 24 for any 32-bit dividend, 7 for the day counts it gets
    localparam logic [ALU_W-1:0] RECIP_60      = 32'h8888_8889; // ceil(2^37 / 60)
    localparam logic [ALU_W-1:0] RECIP_24      = 32'hAAAA_AAAB; // ceil(2^36 / 24)
    localparam logic [ALU_W-1:0] RECIP_7       = 32'h9249_2493; // ceil(2^34 / 7)

    // cumulative days before each month, index 0 is January
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // 400/100/4 rule; the century checks cover the reachable years
    function automatic logic is_leap(input logic [11:0] y);
        logic r;
        r = (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100);
        return r;
    endfunction

endpackage

>>> hdl/ustcd_alu.sv
module ustcd_alu (
    input  logic [ustcd_pkg::ALU_W-1:0]   a,
    input  logic [ustcd_pkg::ALU_W-1:0]   b,
    output logic [2*ustcd_pkg::ALU_W-1:0] prod,
    output logic [ustcd_pkg::ALU_W-1:0]   diff,
    output logic                          ge
);
    import ustcd_pkg::*;

    logic [ALU_W:0] sub;

    assign prod = {{ALU_W{1'b0}}, a} * {{ALU_W{1'b0}}, b};
    assign sub  = {1'b0, a} - {1'b0, b};
    assign diff = sub[ALU_W-1:0];
    assign ge   = ~sub[ALU_W];

endmodule

>>> hdl/unix_seconds_to_calendar_date.sv
// Converts unsigned 32-bit seconds since 1970-01-01 00:00:00 into date, time of
// day and weekday (Sunday is 1). Pulse start while busy is low; busy then stays
// high until the result appears for exactly one cycle with done, and the
// result ports are only meaningful in that cycle; the receiver cannot stall.
// Starts are taken only while idle, so a conversion ends before the next one
// begins. The year search covers 0..136 years past 1970, the month search 1..12.
// All steps share one unit with a 32x32 multiplier and a 32-bit
// subtract/compare: each division by 60, 60, 24 and 7 is a reciprocal
// multiply, a multiply back and a subtract, then one year per cycle, one
// month per cycle. A new start is taken in the same cycle that done is high.
module unix_seconds_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [31:0] unix_seconds,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number,
    output logic [2:0]  weekday_number
);
    import ustcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_Q,
        S_DIV_P,
        S_DIV_R,
        S_YEAR,
        S_ADJ,
        S_MONTH,
        S_DAY
    } state_t;

    typedef enum logic [1:0] {
        DS_SEC,
        DS_MIN,
        DS_HR,
        DS_WDAY
    } div_stage_t;

    state_t      state_reg, state_next;
    div_stage_t  stage_reg, stage_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] p_reg, p_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hr_reg, hr_next;
    logic [15:0] days_reg, days_next;
    logic [2:0]  wd_reg, wd_next;
    logic [11:0] year_reg, year_next;
    logic        adj_reg, adj_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic        done_reg, done_next;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
    logic [2*ALU_W-1:0] alu_prod;
    logic               alu_ge;
    logic               leap;

    ustcd_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .prod (alu_prod),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign leap = is_leap(year_reg);

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        days_next  = days_reg;
        wd_next    = wd_reg;
        year_next  = year_reg;
        adj_next   = adj_reg;
        month_next = month_reg;
        day_next   = day_reg;
        done_next  = 1'b0;
        alu_a      = x_reg;
        alu_b      = 32'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next     = unix_seconds;
                    stage_next = DS_SEC;
                    state_next = S_DIV_Q;
                end
            end
            S_DIV_Q:
            begin
                alu_a = x_reg;
                case (stage_reg)
                    DS_SEC, DS_MIN:
                    begin
                        alu_b  = RECIP_60;
                        q_next = {5'd0, alu_prod[63:37]};
                    end
                    DS_HR:
                    begin
                        alu_b  = RECIP_24;
                        q_next = {4'd0, alu_prod[63:36]};
                    end
                    default:
                    begin
                        alu_b  = RECIP_7;
                        q_next = {2'd0, alu_prod[63:34]};
                    end
                endcase
                state_next = S_DIV_P;
            end
            S_DIV_P:
            begin
                alu_a = q_reg;
                case (stage_reg)
                    DS_SEC:  alu_b = SEC_PER_MIN;
                    DS_MIN:  alu_b = MIN_PER_HOUR;
                    DS_HR:   alu_b = HOUR_PER_DAY;
                    default: alu_b = DAY_PER_WEEK;
                endcase
                p_next     = alu_prod[31:0];
                state_next = S_DIV_R;
            end
            S_DIV_R:
            begin
                alu_a      = x_reg;
                alu_b      = p_reg;
                state_next = S_DIV_Q;
                case (stage_reg)
                    DS_SEC:
                    begin
                        sec_next   = alu_diff[5:0];
                        x_next     = q_reg;
                        stage_next = DS_MIN;
                    end
                    DS_MIN:
                    begin
                        min_next   = alu_diff[5:0];
                        x_next     = q_reg;
                        stage_next = DS_HR;
                    end
                    DS_HR:
                    begin
                        hr_next    = alu_diff[4:0];
                        days_next  = q_reg[15:0];
                        x_next     = q_reg + WDAY_OFFSET;
                        stage_next = DS_WDAY;
                    end
                    default:
                    begin
                        wd_next    = alu_diff[2:0] + 3'd1;
                        year_next  = EPOCH_YEAR;
                        state_next = S_YEAR;
                    end
                endcase
            end
            S_YEAR:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = DAYS_PER_YEAR + {31'd0, leap};
                if (alu_ge)
                begin
                    days_next = alu_diff[15:0];
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                alu_a      = {16'd0, days_reg};
                alu_b      = {23'd0, cum_days(4'd2)};
                adj_next   = leap && alu_ge;
                month_next = 4'd1;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {23'd0, cum_days(month_reg)} + {31'd0, adj_reg};
                if (month_reg != LAST_MONTH && alu_ge)
                    month_next = month_reg + 4'd1;
                else
                    state_next = S_DAY;
            end
            S_DAY:
            begin
                alu_a = {16'd0, days_reg};
                alu_b = {23'd0, cum_days(month_reg - 4'd1)};
                // leap year from March on: the extra day is already in the count
                day_next   = alu_diff[4:0] + {4'd0, !(leap && month_reg >= MARCH)};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= DS_SEC;
            x_reg     <= 32'd0;
            q_reg     <= 32'd0;
            p_reg     <= 32'd0;
            sec_reg   <= 6'd0;
            min_reg   <= 6'd0;
            hr_reg    <= 5'd0;
            days_reg  <= 16'd0;
            wd_reg    <= 3'd0;
            year_reg  <= 12'd0;
            adj_reg   <= 1'b0;
            month_reg <= 4'd0;
            day_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            x_reg     <= x_next;
            q_reg     <= q_next;
            p_reg     <= p_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hr_reg    <= hr_next;
            days_reg  <= days_next;
            wd_reg    <= wd_next;
            year_reg  <= year_next;
            adj_reg   <= adj_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            done_reg  <= done_next;
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign second_of_minute = sec_reg;
    assign minute_of_hour   = min_reg;
    assign hour_of_day      = hr_reg;
    assign day_of_month     = day_reg;
    assign month_number     = month_reg;
    assign year_number      = year_reg;
    assign weekday_number   = wd_reg;

endmodule

>>> hdl/ustcd_checker.sv
module ustcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] unix_seconds,
    input logic [5:0]  second_of_minute,
    input logic [5:0]  minute_of_hour,
    input logic [4:0]  hour_of_day,
    input logic [4:0]  day_of_month,
    input logic [3:0]  month_number,
    input logic [11:0] year_number,
    input logic [2:0]  weekday_number
);

    // a transaction taken makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("done without a preceding busy period");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> second_of_minute <= 6'd59 && minute_of_hour <= 6'd59
              && hour_of_day <= 5'd23 && day_of_month != 5'd0
              && month_number != 4'd0 && month_number <= 4'd12
              && weekday_number != 3'd0
              && year_number >= 12'd1970 && year_number <= 12'd2106)
        else $error("result field out of range");

endmodule

bind unix_seconds_to_calendar_date ustcd_checker u_ustcd_checker (.*);

>>> bench/unix_seconds_to_calendar_date_tb.sv
typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  wday;
} cal_date_t;

class date_scoreboard;
    cal_date_t   pending_q[$];
    int unsigned errors;
    int unsigned matched;
    int unsigned leap_days;
    int unsigned min_year = 4095;
    int unsigned max_year = 0;
    int unsigned month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned year_len(int unsigned y);
        return 365 + int'(leap_year(y));
    endfunction

    function cal_date_t convert(logic [31:0] secs);
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned extra;
        int unsigned mon;
        cal_date_t   d;
        t      = secs;
        d.sec  = 6'(t % 60);
        t      = t / 60;
        d.min  = 6'(t % 60);
        t      = t / 60;
        d.hour = 5'(t % 24);
        days   = t / 24;
        d.wday = 3'((days + 4) % 7 + 1);
        yr = 1970;
        while (days >= year_len(yr))
        begin
            days -= year_len(yr);
            yr++;
        end
        extra = (leap_year(yr) && days >= month_start[2]) ? 1 : 0;
        mon = 1;
        while (mon < 12 && days >= month_start[mon] + extra)
            mon++;
        // past Feb 29 the extra day is already absorbed by the month search
        if (leap_year(yr) && days > month_start[2])
            d.mday = 5'(days - month_start[mon - 1]);
        else
            d.mday = 5'(days - month_start[mon - 1] + 1);
        d.month = 4'(mon);
        d.year  = 12'(yr);
        return d;
    endfunction

    task report(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task note(logic [31:0] secs);
        cal_date_t d;
        d = convert(secs);
        pending_q.push_back(d);
        if (d.month == 2 && d.mday == 29)
            leap_days++;
        if (d.year < min_year)
            min_year = d.year;
        if (d.year > max_year)
            max_year = d.year;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    endtask

    task check(cal_date_t got);
        cal_date_t want;
        if (pending_q.size() == 0)
        begin
            report("result strobe with no transaction outstanding");
            return;
        end
        want = pending_q.pop_front();
        compare_field("second_of_minute", got.sec, want.sec);
        compare_field("minute_of_hour", got.min, want.min);
        compare_field("hour_of_day", got.hour, want.hour);
        compare_field("day_of_month", got.mday, want.mday);
        compare_field("month_number", got.month, want.month);
        compare_field("year_number", got.year, want.year);
        compare_field("weekday_number", got.wday, want.wday);
        matched++;
    endtask
endclass

module unix_seconds_to_calendar_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_RANDOM = 750;
    localparam int unsigned DRAIN_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [31:0] unix_seconds;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
    logic [2:0]  weekday_number;
    cal_date_t   result_now;

    date_scoreboard sb = new();
    int unsigned    sent;

    unix_seconds_to_calendar_date u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .done             (done),
        .unix_seconds     (unix_seconds),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_number     (month_number),
        .year_number      (year_number),
        .weekday_number   (weekday_number)
    );

    always #2 clk = ~clk;

    assign result_now = {second_of_minute, minute_of_hour, hour_of_day, day_of_month,
                         month_number, year_number, weekday_number};

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(result_now);
    end

    task automatic send_item(input logic [31:0] secs, input bit may_idle);
        int unsigned gap;
        if (may_idle && $urandom_range(0, 99) < 31)
        begin
            gap = $urandom_range(1, 260);
            @(negedge clk);
            start        <= 1'b0;
            unix_seconds <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        unix_seconds <= secs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(secs);
        sent++;
    endtask

    // seconds close to a year start, the end of February or a year end, or on any day of the year
    function automatic logic [31:0] near_boundary();
        int unsigned     yr;
        int unsigned     off;
        longint unsigned days;
        longint unsigned secs;
        yr   = $urandom_range(1970, 2105);
        days = 0;
        for (int unsigned y = 1970; y < yr; y++)
            days += sb.year_len(y);
        case ($urandom_range(0, 3))
            0:       off = $urandom_range(0, 1);
            1:       off = $urandom_range(57, 61);
            2:       off = $urandom_range(363, 365);
            default: off = $urandom_range(0, 365);
        endcase
        secs = (days + off) * 86400 + $urandom_range(0, 86399);
        if (secs > 64'hFFFF_FFFF)
            return $urandom;
        return secs[31:0];
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        logic [31:0] v;
        rst_n        = 1'b0;
        start        = 1'b0;
        unix_seconds = '0;
        directed = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                     32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                     32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
                     32'd94694399, 32'd94694400, 32'd951782399, 32'd951782400,
                     32'd951868800, 32'd978307199, 32'd4107456000, 32'd4107542400,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i], 1'b1);

        for (int unsigned i = 0; i < NUM_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = $urandom;
                4, 5, 6, 7: v = near_boundary();
                8:          v = $urandom_range(0, 200000);
                default:    v = 32'hFFFF_FFFF - $urandom_range(0, 200000);
            endcase
            // back-to-back stretch in the middle of the run
            send_item(v, !(i >= 300 && i < 420));
        end
        @(negedge clk);
        start <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent, %0d results checked, %0d mismatches", sent,
                 sb.matched, sb.errors);
        $display("years %0d to %0d reached, %0d dates on Feb 29", sb.min_year, sb.max_year,
                 sb.leap_days);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting for the block");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
